[src/wsd_pkg.sv]
`timescale 1ns / 1ps

package wsd_pkg;

  // Width of the payload length counter; longer extended lengths saturate.
  localparam int LENGTH_BITS = 64;

  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_KEY     = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_DEAD    = 3'd5;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  localparam logic [2:0] FT_TEXT    = 3'd0;
  localparam logic [2:0] FT_BINARY  = 3'd1;
  localparam logic [2:0] FT_CLOSE   = 3'd2;
  localparam logic [2:0] FT_PING    = 3'd3;
  localparam logic [2:0] FT_PONG    = 3'd4;
  localparam logic [2:0] FT_UNKNOWN = 3'd7;

  localparam logic [6:0] LEN_CODE_16 = 7'h7E;
  localparam logic [6:0] LEN_CODE_64 = 7'h7F;
  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  typedef struct packed {
    logic [2:0]             phase;
    logic [3:0]             opcode;
    logic                   mask_present;
    logic [LENGTH_BITS-1:0] len;
    logic                   len_ovf;
    logic [3:0]             hdr_cnt;
    logic [31:0]            key;
    logic [1:0]             key_idx;
  } ws_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] ftype;
    logic       last;
  } ws_result_t;

  function automatic logic [2:0] op_type(input logic [3:0] op);
    logic [2:0] t;
    unique case (op)
      OP_TEXT:   t = FT_TEXT;
      OP_BINARY: t = FT_BINARY;
      OP_CLOSE:  t = FT_CLOSE;
      OP_PING:   t = FT_PING;
      OP_PONG:   t = FT_PONG;
      default:   t = FT_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

[src/wsd_step.sv]
`timescale 1ns / 1ps

module wsd_step
  import wsd_pkg::*;
(
  input  ws_state_t  cur,
  input  logic [7:0] rx_byte,
  output ws_state_t  nxt,
  output logic       res_valid,
  output ws_result_t res
);

  logic [2:0]             cur_type;
  logic [3:0]             op_in;
  logic [2:0]             type_in;
  logic [6:0]             len_code;
  logic [LENGTH_BITS-1:0] len_shift;
  logic                   ovf_shift;
  logic [3:0]             cnt_m1;
  logic [LENGTH_BITS-1:0] len_done;
  logic [7:0]             key_byte;
  logic                   hdr_end;
  logic                   len_is_one;

  assign cur_type   = op_type(cur.opcode);
  assign op_in      = rx_byte[3:0];
  assign type_in    = op_type(op_in);
  assign len_code   = rx_byte[6:0];
  assign len_shift  = {cur.len[LENGTH_BITS-9:0], rx_byte};
  // bits pushed out of the counter window mean the length does not fit
  assign ovf_shift  = cur.len_ovf | (|cur.len[LENGTH_BITS-1 -: 8]);
  assign cnt_m1     = cur.hdr_cnt - 4'd1;
  assign len_done   = ovf_shift ? {LENGTH_BITS{1'b1}} : len_shift;
  assign len_is_one = (cur.len == LENGTH_BITS'(1));

  always_comb begin
    unique case (cur.key_idx)
      2'd0:    key_byte = cur.key[31:24];
      2'd1:    key_byte = cur.key[23:16];
      2'd2:    key_byte = cur.key[15:8];
      default: key_byte = cur.key[7:0];
    endcase
  end

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    hdr_end   = 1'b0;

    unique case (cur.phase)
      PH_HDR0: begin
        nxt.opcode = op_in;
        if (type_in == FT_UNKNOWN) begin
          res_valid  = 1'b1;
          res.kind   = KIND_ERROR;
          res.ftype  = FT_TEXT;
          res.last   = 1'b1;
          nxt.phase  = PH_DEAD;
        end else begin
          nxt.phase  = PH_HDR1;
        end
      end

      PH_HDR1: begin
        nxt.mask_present = rx_byte[7];
        nxt.key          = '0;
        nxt.len_ovf      = 1'b0;
        if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64) begin
          nxt.len     = '0;
          nxt.hdr_cnt = (len_code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
          nxt.phase   = PH_EXTLEN;
        end else begin
          nxt.len = LENGTH_BITS'(len_code);
          if (rx_byte[7]) begin
            nxt.hdr_cnt = KEY_BYTES;
            nxt.phase   = PH_KEY;
          end else begin
            hdr_end = 1'b1;
          end
        end
      end

      PH_EXTLEN: begin
        nxt.hdr_cnt = cnt_m1;
        nxt.len_ovf = ovf_shift;
        if (cnt_m1 != 4'd0) begin
          nxt.len = len_shift;
        end else begin
          nxt.len = len_done;
          if (cur.mask_present) begin
            nxt.hdr_cnt = KEY_BYTES;
            nxt.phase   = PH_KEY;
          end else begin
            hdr_end = 1'b1;
          end
        end
      end

      PH_KEY: begin
        nxt.key     = {cur.key[23:0], rx_byte};
        nxt.hdr_cnt = cnt_m1;
        if (cnt_m1 == 4'd0) begin
          hdr_end = 1'b1;
        end
      end

      PH_PAYLOAD: begin
        nxt.key_idx = cur.key_idx + 2'd1;
        nxt.len     = cur.len - LENGTH_BITS'(1);
        res_valid   = 1'b1;
        res.kind    = KIND_PAYLOAD;
        res.data    = rx_byte ^ key_byte;
        res.ftype   = cur_type;
        res.last    = len_is_one;
        if (len_is_one) begin
          nxt.phase = (cur_type == FT_CLOSE) ? PH_DEAD : PH_HDR0;
        end
      end

      default: begin
        nxt.phase = PH_DEAD;
      end
    endcase

    // header complete: start the payload or report an empty frame
    if (hdr_end) begin
      nxt.key_idx = 2'd0;
      if (nxt.len == '0) begin
        res_valid = 1'b1;
        res.kind  = KIND_EMPTY;
        res.ftype = cur_type;
        res.last  = 1'b1;
        nxt.phase = (cur_type == FT_CLOSE) ? PH_DEAD : PH_HDR0;
      end else begin
        nxt.phase = PH_PAYLOAD;
      end
    end
  end

endmodule

[src/websocket_frame_deframer_core.sv]
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// in_       in_valid / in_stall   in_rx_byte[7:0]
// out_      out_valid / out_stall out_result_kind, out_payload_byte, out_frame_type,
//                                 out_frame_last
//
// One byte per cycle sustained while out_stall is low; a byte passes from input
// transaction to result through the input register, then the result register.
// Header bytes that complete no result produce no out_ transaction.
// rst_n is synchronous; it returns the parser to the first header byte.
// in_stall rises only when a byte is held and the result register is full
// and stalled; after a close frame or an unknown opcode every byte is consumed.

module websocket_frame_deframer_core
  import wsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_result_kind,
  output logic [7:0] out_payload_byte,
  output logic [2:0] out_frame_type,
  output logic       out_frame_last
);

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       out_valid_r, out_valid_nxt;
  ws_result_t out_res_r;
  ws_state_t  st_r, st_nxt;
  ws_result_t step_res;
  logic       step_valid;
  logic       in_take;
  logic       adv;

  // a held byte moves on once the result register has room
  assign adv      = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  wsd_step u_step (
    .cur       (st_r),
    .rx_byte   (in_byte_r),
    .nxt       (st_nxt),
    .res_valid (step_valid),
    .res       (step_res)
  );

  always_comb begin
    in_valid_nxt = in_take ? 1'b1 : (adv ? 1'b0 : in_valid_r);
    if (adv) begin
      out_valid_nxt = step_valid;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '{phase: PH_HDR0, default: '0};
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_rx_byte;
    end
    if (adv && step_valid) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_res_r.kind;
  assign out_payload_byte = out_res_r.data;
  assign out_frame_type   = out_res_r.ftype;
  assign out_frame_last   = out_res_r.last;

`ifndef SYNTHESIS
  a_dead_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_DEAD |=> st_r.phase == PH_DEAD)
    else $error("parser left the dead state");

  a_error_kills: assert property (@(posedge clk) disable iff (!rst_n)
    adv && step_valid && step_res.kind == KIND_ERROR |=> st_r.phase == PH_DEAD)
    else $error("error result did not stop the parser");

  a_payload_len: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_PAYLOAD |-> st_r.len != '0)
    else $error("payload phase with zero remaining length");

  a_nonpayload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind != KIND_PAYLOAD |-> out_res_r.data == 8'd0 && out_res_r.last)
    else $error("non-payload result carries data or is not last");
`endif

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import wsd_pkg::*;

  localparam int LEN_FORM_7  = 0;
  localparam int LEN_FORM_16 = 1;
  localparam int LEN_FORM_64 = 2;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int MAX_PRINTED = 30;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_result_kind;
  logic [7:0] out_payload_byte;
  logic [2:0] out_frame_type;
  logic       out_frame_last;

  websocket_frame_deframer_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_payload_byte (out_payload_byte),
    .out_frame_type   (out_frame_type),
    .out_frame_last   (out_frame_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Parser state mirrored on the testbench side
  logic [2:0]  rx_phase = PH_HDR0;
  logic [3:0]  rx_opcode = '0;
  logic        rx_masked = 1'b0;
  logic [63:0] rx_remaining = '0;
  logic [3:0]  rx_hdr_left = '0;
  logic [31:0] rx_key = '0;
  logic [1:0]  rx_key_pos = '0;

  ws_result_t expected_results[$];

  int error_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int input_stalls = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;
  string ending_name = "none";

  initial begin
    #3_000_000;
    $display("Timeout: %0d results still outstanding", expected_results.size());
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [2:0] frame_type_of(input logic [3:0] op);
    case (op)
      OP_TEXT:   return FT_TEXT;
      OP_BINARY: return FT_BINARY;
      OP_CLOSE:  return FT_CLOSE;
      OP_PING:   return FT_PING;
      OP_PONG:   return FT_PONG;
      default:   return FT_UNKNOWN;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTED)
      $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic queue_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic [2:0] ftype, input logic last);
    ws_result_t r;
    r.kind  = kind;
    r.data  = data;
    r.ftype = ftype;
    r.last  = last;
    expected_results.push_back(r);
  endtask

  task automatic finish_header();
    logic [2:0] ft;
    ft = frame_type_of(rx_opcode);
    rx_key_pos = '0;
    if (rx_remaining == 0) begin
      queue_result(KIND_EMPTY, 8'h00, ft, 1'b1);
      rx_phase = (ft == FT_CLOSE) ? PH_DEAD : PH_HDR0;
    end else begin
      rx_phase = PH_PAYLOAD;
    end
  endtask

  task automatic finish_length();
    if (rx_masked) begin
      rx_hdr_left = KEY_BYTES;
      rx_phase = PH_KEY;
    end else begin
      finish_header();
    end
  endtask

  // Advance the mirrored parser by one accepted byte
  task automatic parse_byte(input logic [7:0] b);
    logic [2:0]  ft;
    logic [7:0]  k;
    logic [63:0] len_max;
    ft = frame_type_of(rx_opcode);
    len_max = (64'd1 << LENGTH_BITS) - 64'd1;
    case (rx_phase)
      PH_HDR0: begin
        rx_opcode = b[3:0];
        if (frame_type_of(b[3:0]) == FT_UNKNOWN) begin
          // error results carry type code zero
          queue_result(KIND_ERROR, 8'h00, FT_TEXT, 1'b1);
          rx_phase = PH_DEAD;
        end else begin
          rx_phase = PH_HDR1;
        end
      end
      PH_HDR1: begin
        rx_masked = b[7];
        rx_key = '0;
        rx_remaining = '0;
        if (b[6:0] == LEN_CODE_16 || b[6:0] == LEN_CODE_64) begin
          rx_hdr_left = (b[6:0] == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
          rx_phase = PH_EXTLEN;
        end else begin
          rx_remaining = {57'd0, b[6:0]};
          finish_length();
        end
      end
      PH_EXTLEN: begin
        rx_remaining = {rx_remaining[55:0], b};
        rx_hdr_left = rx_hdr_left - 4'd1;
        if (rx_hdr_left == 0) begin
          if (rx_remaining > len_max)
            rx_remaining = len_max;
          finish_length();
        end
      end
      PH_KEY: begin
        rx_key = {rx_key[23:0], b};
        rx_hdr_left = rx_hdr_left - 4'd1;
        if (rx_hdr_left == 0)
          finish_header();
      end
      PH_PAYLOAD: begin
        k = rx_key[8 * (3 - rx_key_pos) +: 8];
        rx_key_pos = rx_key_pos + 2'd1;
        rx_remaining = rx_remaining - 64'd1;
        queue_result(KIND_PAYLOAD, b ^ k, ft, rx_remaining == 0);
        if (rx_remaining == 0)
          rx_phase = (ft == FT_CLOSE) ? PH_DEAD : PH_HDR0;
      end
      default: rx_phase = PH_DEAD;
    endcase
  endtask

  // Receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_seen != hold_gen) begin
      hold_seen <= hold_gen;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    ws_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_result_kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_result_kind, want.kind));
        if (out_payload_byte !== want.data)
          report_mismatch($sformatf("byte %02h, expected %02h", out_payload_byte, want.data));
        if (out_frame_type !== want.ftype)
          report_mismatch($sformatf("type %0d, expected %0d", out_frame_type, want.ftype));
        if (out_frame_last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_frame_last, want.last));
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) begin
      input_stalls++;
      @(posedge clk);
    end
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [3:0] op, input logic masked,
                             input logic [63:0] len, input int form,
                             input logic [31:0] key);
    logic [3:0] flags;
    flags = 4'($urandom_range(15));  // FIN and RSV bits, ignored by the block
    send_byte({flags, op});
    case (form)
      LEN_FORM_7: send_byte({masked, len[6:0]});
      LEN_FORM_16: begin
        send_byte({masked, LEN_CODE_16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN_CODE_64});
        for (int i = 7; i >= 0; i--)
          send_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 3; i >= 0; i--)
        send_byte(key[8 * i +: 8]);
    frames_sent++;
  endtask

  task automatic send_frame(input logic [3:0] op, input logic masked,
                            input logic [63:0] len, input int form,
                            input logic [31:0] key);
    send_header(op, masked, len, form, key);
    repeat (int'(len))
      send_byte(8'($urandom));
  endtask

  // Sender pauses until every expected result is back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_header(OP_TEXT, 1'b0, 64'd1, LEN_FORM_7, 32'h0);
    send_byte(8'hFF);
    // key index wraps after four payload bytes
    send_header(OP_BINARY, 1'b1, 64'd5, LEN_FORM_7, 32'hFFFF_FFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h0F);
    send_byte(8'hF0);
    send_byte(8'h55);
    send_header(OP_PING, 1'b0, 64'd0, LEN_FORM_7, 32'h0);
    send_header(OP_PONG, 1'b1, 64'd0, LEN_FORM_16, 32'h0);
    wait_for_results();
  endtask

  task automatic test_random_frames(input int n_bytes, input int send_idle,
                                    input int recv_stall);
    logic [3:0]  ops [4];
    logic [3:0]  op;
    logic [63:0] len;
    logic [31:0] key;
    int          form;
    int          r;
    int          stop_at;
    ops = '{OP_TEXT, OP_BINARY, OP_PING, OP_PONG};
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      op = ops[2'($urandom_range(3))];
      r = $urandom_range(99);
      if (r < 70) begin
        form = LEN_FORM_7;
        len = ($urandom_range(19) == 0) ? 64'($urandom_range(100, 125))
                                        : 64'($urandom_range(20));
      end else if (r < 88) begin
        // short lengths here are non-minimal encodings, still legal for the parser
        form = LEN_FORM_16;
        len = ($urandom_range(9) == 0) ? 64'($urandom_range(126, 300))
                                       : 64'($urandom_range(40));
      end else begin
        form = LEN_FORM_64;
        len = 64'($urandom_range(40));
      end
      r = $urandom_range(9);
      key = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : 32'($urandom);
      send_frame(op, 1'($urandom_range(1)), len, form, key);
    end
    wait_for_results();
  endtask

  // Receiver holds off long while the sender keeps pushing one frame
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_gen++;
    send_frame(OP_BINARY, 1'b1, 64'd100, LEN_FORM_16, 32'($urandom));
    wait_for_results();
  endtask

  // Closing cases leave the block dead or in an endless frame, so one per run
  task automatic test_terminal_case();
    logic [3:0] op;
    int         pick;
    send_idle_pct = 20;
    recv_stall_pct = 20;
    pick = $urandom_range(2);
    case (pick)
      0: begin
        ending_name = "close frame";
        send_frame(OP_CLOSE, 1'($urandom_range(1)), 64'($urandom_range(5)), LEN_FORM_7,
                   32'($urandom));
      end
      1: begin
        ending_name = "unknown opcode";
        do op = 4'($urandom_range(15)); while (frame_type_of(op) != FT_UNKNOWN);
        send_byte({4'($urandom_range(15)), op});
      end
      default: begin
        ending_name = "maximum 64-bit length";
        // header only: the payload never ends within the run
        send_header(OP_TEXT, 1'($urandom_range(1)), 64'hFFFF_FFFF_FFFF_FFFF, LEN_FORM_64,
                    32'($urandom));
      end
    endcase
    // trailing bytes: ignored when dead, mid-payload for the endless frame
    send_byte({4'h8, OP_TEXT});
    send_byte(8'h05);
    repeat (10) send_byte(8'($urandom));
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_frames(380, 0, 0);
    test_random_frames(380, 83, 0);
    test_random_frames(380, 0, 83);
    test_random_frames(300, 11, 11);
    test_backpressure();
    test_terminal_case();

    $display("Sent %0d bytes in %0d frames, checked %0d results, %0d input stall cycles",
             bytes_sent, frames_sent, results_checked, input_stalls);
    $display("Idle/stall mixes and a long receiver hold-off covered; final case: %s",
             ending_name);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", error_count);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
